>>> rtl/core/rsa_pkg.sv
// Shared types, constants and the label table of the recency slot allocator.
package rsa_pkg;

   localparam int NUM_SLOTS_DEF = 63;

   localparam int FUNC_W  = 3;
   localparam int LABEL_W = 8;
   localparam int RANK_W  = 6;
   localparam int SLOT_W  = 6;
   localparam int LBOUT_W = 6;
   localparam int COUNT_W = 6;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE    = 3'd0,
      FUNC_FORGET    = 3'd1,
      FUNC_FETCH     = 3'd2,
      FUNC_READ_RANK = 3'd3,
      FUNC_CHECK     = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_GET_D,
      ST_SH_RD,
      ST_SH_WR,
      ST_FINISH,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // latch request fields and label lookup
      logic pick_free;  // take scan slot, read its rank
      logic scan_step;  // advance free-slot scan
      logic s2r_read;   // read rank of selected slot
      logic idx_load;   // shift index <= rank read back
      logic sh_read;    // read neighbor entry of the recency list
      logic sh_write;   // move neighbor one rank, step index
      logic finish;     // place slot at end rank, update flag and count
      logic rank_read;  // read recency list at requested rank
      logic rank_take;  // slot <= entry read at rank
      logic set_ok;     // mark success
      logic res_load;   // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     label_hit;
      logic     slot_active;
      logic     pool_full;
      logic     rank_hit;
      logic     scan_free;
      logic     d_at_end;
      logic     step_at_end;
   } sts_type;

   localparam logic [5:0] LABEL_ROM [64] = '{
      6'd58, 6'd10, 6'd15, 6'd1,  6'd27, 6'd52, 6'd14, 6'd3,
      6'd61, 6'd13, 6'd31, 6'd30, 6'd45, 6'd28, 6'd41, 6'd55,
      6'd33, 6'd20, 6'd62, 6'd34, 6'd42, 6'd18, 6'd57, 6'd47,
      6'd24, 6'd49, 6'd19, 6'd50, 6'd25, 6'd38, 6'd40, 6'd2,
      6'd21, 6'd39, 6'd59, 6'd22, 6'd60, 6'd4,  6'd6,  6'd16,
      6'd29, 6'd37, 6'd48, 6'd46, 6'd54, 6'd43, 6'd32, 6'd56,
      6'd51, 6'd7,  6'd9,  6'd63, 6'd5,  6'd8,  6'd36, 6'd44,
      6'd26, 6'd11, 6'd23, 6'd17, 6'd53, 6'd35, 6'd12, 6'd0
   };

   // {found, slot}: inverse lookup of the label table
   function automatic logic [6:0] find_label(logic [LABEL_W-1:0] label);
      logic [6:0] res;
      res = '0;
      for (int i = 0; i < 64; i++) begin
         if (label[7:6] == 2'b00 && LABEL_ROM[i] == label[5:0]) begin
            res = {1'b1, 6'(i)};
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/core/rsa_req_if.sv
// Request channel: operation code, label and rank with valid/ready.
interface rsa_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsa_pkg::FUNC_W-1:0]  func;
   logic [rsa_pkg::LABEL_W-1:0] label;
   logic [rsa_pkg::RANK_W-1:0]  rank;

   modport source (output valid, output func, output label, output rank, input ready);
   modport sink   (input valid, input func, input label, input rank, output ready);
endinterface

>>> rtl/core/rsa_rsp_if.sv
// Response channel: status, slot, label and counts with valid/ready.
interface rsa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [rsa_pkg::SLOT_W-1:0]  slot_index;
   logic [rsa_pkg::LBOUT_W-1:0] label_out;
   logic [rsa_pkg::COUNT_W-1:0] active_count;
   logic [rsa_pkg::COUNT_W-1:0] free_count;

   modport source (output valid, output ok, output slot_index, output label_out,
                   output active_count, output free_count, input ready);
   modport sink   (input valid, input ok, input slot_index, input label_out,
                   input active_count, input free_count, output ready);
endinterface

>>> rtl/core/rsa_ctrl.sv
// Operation sequencer of the recency slot allocator.
module rsa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsa_pkg::sts_type sts,
   output rsa_pkg::cmd_type cmd
);

   rsa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsa_pkg::ST_IDLE: begin
            if (req_valid) state_in = rsa_pkg::ST_DECODE;
         end
         rsa_pkg::ST_DECODE: begin
            case (sts.func)
               rsa_pkg::FUNC_CREATE:
                  state_in = sts.pool_full ? rsa_pkg::ST_RESP : rsa_pkg::ST_SCAN;
               rsa_pkg::FUNC_FORGET:
                  state_in = sts.slot_active ? rsa_pkg::ST_GET_D : rsa_pkg::ST_RESP;
               rsa_pkg::FUNC_READ_RANK:
                  state_in = sts.rank_hit ? rsa_pkg::ST_RD_WAIT : rsa_pkg::ST_RESP;
               default:
                  state_in = rsa_pkg::ST_RESP;
            endcase
         end
         rsa_pkg::ST_SCAN: begin
            if (sts.scan_free) state_in = rsa_pkg::ST_GET_D;
         end
         rsa_pkg::ST_GET_D: begin
            state_in = sts.d_at_end ? rsa_pkg::ST_FINISH : rsa_pkg::ST_SH_RD;
         end
         rsa_pkg::ST_SH_RD: begin
            state_in = rsa_pkg::ST_SH_WR;
         end
         rsa_pkg::ST_SH_WR: begin
            state_in = sts.step_at_end ? rsa_pkg::ST_FINISH : rsa_pkg::ST_SH_RD;
         end
         rsa_pkg::ST_FINISH: begin
            state_in = rsa_pkg::ST_RESP;
         end
         rsa_pkg::ST_RD_WAIT: begin
            state_in = rsa_pkg::ST_RESP;
         end
         rsa_pkg::ST_RESP: begin
            if (out_free) state_in = rsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = rsa_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rsa_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         rsa_pkg::ST_DECODE: begin
            case (sts.func)
               rsa_pkg::FUNC_FORGET:    cmd.s2r_read  = sts.slot_active;
               rsa_pkg::FUNC_FETCH:     cmd.set_ok    = sts.slot_active;
               rsa_pkg::FUNC_READ_RANK: cmd.rank_read = sts.rank_hit;
               rsa_pkg::FUNC_CHECK:     cmd.set_ok    = sts.label_hit;
               default:                 cmd.set_ok    = 1'b0;
            endcase
         end
         rsa_pkg::ST_SCAN: begin
            cmd.pick_free = sts.scan_free;
            cmd.scan_step = !sts.scan_free;
         end
         rsa_pkg::ST_GET_D:   cmd.idx_load  = 1'b1;
         rsa_pkg::ST_SH_RD:   cmd.sh_read   = 1'b1;
         rsa_pkg::ST_SH_WR:   cmd.sh_write  = 1'b1;
         rsa_pkg::ST_FINISH:  cmd.finish    = 1'b1;
         rsa_pkg::ST_RD_WAIT: cmd.rank_take = 1'b1;
         rsa_pkg::ST_RESP:    cmd.res_load  = out_free;
         default:             cmd           = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/rsa_datapath.sv
// Recency list, inverse rank table, active flags, count and output register.
module rsa_datapath #(
   parameter int NUM_SLOTS = rsa_pkg::NUM_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rsa_pkg::cmd_type            cmd,
   output rsa_pkg::sts_type            sts,
   input  logic [rsa_pkg::FUNC_W-1:0]  req_func,
   input  logic [rsa_pkg::LABEL_W-1:0] req_label,
   input  logic [rsa_pkg::RANK_W-1:0]  req_rank,
   output logic                        rsp_ok,
   output logic [rsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [rsa_pkg::LBOUT_W-1:0] rsp_label_out,
   output logic [rsa_pkg::COUNT_W-1:0] rsp_active_count,
   output logic [rsa_pkg::COUNT_W-1:0] rsp_free_count
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   // request and working registers
   rsa_pkg::func_type         func_ff;
   logic [rsa_pkg::RANK_W-1:0] rank_ff;
   logic                      hit_ff;
   logic [SW-1:0]             slot_ff, slot_in;
   logic                      ok_ff, ok_in;
   logic                      lab_ff, lab_in;
   logic [SW-1:0]             scan_ff, idx_ff;
   logic [CW-1:0]             total_ff;
   logic [NUM_SLOTS-1:0]      active_ff;

   // recency list and its inverse; entry not yet written reads as its index
   logic [SW-1:0]        r2s_mem [NUM_SLOTS];
   logic [SW-1:0]        s2r_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] r2s_vld_ff, s2r_vld_ff;
   logic [SW-1:0]        r2s_q_ff, r2s_a_ff, s2r_q_ff, s2r_a_ff;
   logic                 r2s_v_ff, s2r_v_ff;
   logic [SW-1:0]        r2s_out, s2r_out;

   logic                 r2s_re, s2r_re, r2s_we, s2r_we;
   logic [SW-1:0]        r2s_ra, s2r_ra, r2s_wa, s2r_wa, r2s_wd, s2r_wd;

   logic [6:0]           find;
   logic                 is_create;
   logic [SW-1:0]        end_pos, idx_step;

   assign find      = rsa_pkg::find_label(req_label);
   assign is_create = (func_ff == rsa_pkg::FUNC_CREATE);
   assign end_pos   = is_create ? '0 : SW'(total_ff - 1'b1);
   assign idx_step  = is_create ? idx_ff - 1'b1 : idx_ff + 1'b1;
   assign r2s_out   = r2s_v_ff ? r2s_q_ff : r2s_a_ff;
   assign s2r_out   = s2r_v_ff ? s2r_q_ff : s2r_a_ff;

   // memory port control
   assign r2s_re = cmd.sh_read || cmd.rank_read;
   assign r2s_ra = cmd.sh_read ? idx_step : SW'(rank_ff);
   assign s2r_re = cmd.s2r_read || cmd.pick_free;
   assign s2r_ra = cmd.pick_free ? scan_ff : slot_ff;
   assign r2s_we = cmd.sh_write || cmd.finish;
   assign r2s_wa = cmd.finish ? end_pos : idx_ff;
   assign r2s_wd = cmd.finish ? slot_ff : r2s_out;
   assign s2r_we = cmd.sh_write || cmd.finish;
   assign s2r_wa = cmd.finish ? slot_ff : r2s_out;
   assign s2r_wd = cmd.finish ? end_pos : idx_ff;

   always_ff @(posedge clock) begin
      if (r2s_we) r2s_mem[r2s_wa] <= r2s_wd;
      if (r2s_re) begin
         r2s_q_ff <= r2s_mem[r2s_ra];
         r2s_v_ff <= r2s_vld_ff[r2s_ra];
         r2s_a_ff <= r2s_ra;
      end
      if (s2r_we) s2r_mem[s2r_wa] <= s2r_wd;
      if (s2r_re) begin
         s2r_q_ff <= s2r_mem[s2r_ra];
         s2r_v_ff <= s2r_vld_ff[s2r_ra];
         s2r_a_ff <= s2r_ra;
      end
   end

   // control state: flags, count, valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         active_ff  <= '0;
         r2s_vld_ff <= '0;
         s2r_vld_ff <= '0;
      end else begin
         if (r2s_we) r2s_vld_ff[r2s_wa] <= 1'b1;
         if (s2r_we) s2r_vld_ff[s2r_wa] <= 1'b1;
         if (cmd.finish) begin
            active_ff[slot_ff] <= is_create;
            total_ff           <= is_create ? total_ff + 1'b1 : total_ff - 1'b1;
         end
      end
   end

   always_comb begin
      slot_in = slot_ff;
      ok_in   = ok_ff;
      lab_in  = lab_ff;
      if (cmd.load_req) begin
         slot_in = SW'(find[5:0]);
         ok_in   = 1'b0;
         lab_in  = 1'b0;
      end
      if (cmd.pick_free) slot_in = scan_ff;
      if (cmd.rank_take) begin
         slot_in = r2s_out;
         ok_in   = 1'b1;
         lab_in  = 1'b1;
      end
      if (cmd.set_ok) ok_in = 1'b1;
      if (cmd.finish) begin
         ok_in  = 1'b1;
         lab_in = is_create;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      ok_ff   <= ok_in;
      lab_ff  <= lab_in;
      if (cmd.load_req) begin
         func_ff <= rsa_pkg::func_type'(req_func);
         rank_ff <= req_rank;
         hit_ff  <= find[6] && (req_label != '0)
                    && ({1'b0, find[5:0]} < 7'(NUM_SLOTS));
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.idx_load) begin
         idx_ff <= s2r_out;
      end else if (cmd.sh_write) begin
         idx_ff <= idx_step;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_ok           <= ok_ff;
         rsp_slot_index   <= ok_ff ? rsa_pkg::SLOT_W'(slot_ff) : '0;
         rsp_label_out    <= (ok_ff && lab_ff) ? rsa_pkg::LABEL_ROM[6'(slot_ff)] : '0;
         rsp_active_count <= rsa_pkg::COUNT_W'(total_ff);
         rsp_free_count   <= rsa_pkg::COUNT_W'(CW'(NUM_SLOTS) - total_ff);
      end
   end

   always_comb begin
      sts.func        = func_ff;
      sts.label_hit   = hit_ff;
      sts.slot_active = hit_ff && active_ff[slot_ff];
      sts.pool_full   = (total_ff == CW'(NUM_SLOTS));
      sts.rank_hit    = (7'(rank_ff) < 7'(total_ff));
      sts.scan_free   = !active_ff[scan_ff];
      sts.d_at_end    = (s2r_out == end_pos);
      sts.step_at_end = (idx_step == end_pos);
   end

endmodule

>>> rtl/core/recency_slot_allocator_core.sv
// Recency slot allocator: move-to-front pool of labeled slots.
//
// Usage: one request transfer on req_ch (func, label, rank) yields exactly one
// response transfer on rsp_ch (ok, slot_index, label_out, active/free counts).
// Requests are handled one at a time; req_ch.ready is high only while the
// sequencer is idle. A finished response sits in an output register, so the
// next request is taken while the receiver stalls; a second finished
// response then waits in the sequencer until the register empties.
// Steps from request transfer to response valid:
//   fetch, check, failed ops: decode, then respond; read rank: decode, a registered read at the rank, then respond
//   forget: d = slot's rank, n = active count - 1; the entries at ranks
//     d+1..n close up by one rank, then the slot goes to rank n
//   create: a linear free scan takes the lowest free slot, d = its old rank;
//     the entries at ranks 0..d-1 slide back by one rank, then the slot goes to rank 0
// Each moved entry of the list shift takes one registered read of the
// recency list, then one write to each of the two tables.
// Reset (synchronous, active high) empties the pool: no slot active, count
// zero, both tables read as identity through per-entry valid bits. No
// clearing pass is needed, the block is ready the cycle after reset.
module recency_slot_allocator_core #(
   parameter int NUM_SLOTS = rsa_pkg::NUM_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rsa_req_if.sink   req_ch,
   rsa_rsp_if.source rsp_ch
);

   rsa_pkg::cmd_type cmd;
   rsa_pkg::sts_type sts;

   // sequencer: handshakes and step order
   rsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, flags, count and response payload
   rsa_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_ch.func),
      .req_label        (req_ch.label),
      .req_rank         (req_ch.rank),
      .rsp_ok           (rsp_ch.ok),
      .rsp_slot_index   (rsp_ch.slot_index),
      .rsp_label_out    (rsp_ch.label_out),
      .rsp_active_count (rsp_ch.active_count),
      .rsp_free_count   (rsp_ch.free_count)
   );

endmodule

>>> rtl/core/rsa_checker.sv
// Port-level checks of the recency slot allocator, bound to the top level.
module rsa_checker #(
   parameter int NUM_SLOTS = rsa_pkg::NUM_SLOTS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_ok,
   input logic [rsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   input logic [rsa_pkg::LBOUT_W-1:0] rsp_label_out,
   input logic [rsa_pkg::COUNT_W-1:0] rsp_active_count,
   input logic [rsa_pkg::COUNT_W-1:0] rsp_free_count
);

   // counts always split the pool
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (7'(rsp_active_count) + 7'(rsp_free_count)) == 7'(NUM_SLOTS))
      else $error("active and free counts do not add up to the pool size");

   // a failed op carries no slot and no label
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_slot_index == '0 && rsp_label_out == '0))
      else $error("failed response with nonzero slot or label");

   // a label is only returned for an active slot, so never with an empty pool
   a_empty_no_label: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_active_count == '0) |-> rsp_label_out == '0)
      else $error("label returned while no slot is active");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
         && $stable(rsp_slot_index) && $stable(rsp_label_out)
         && $stable(rsp_active_count)))
      else $error("response changed while stalled");

endmodule

bind recency_slot_allocator_core rsa_checker #(
   .NUM_SLOTS (NUM_SLOTS)
) u_rsa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_ok           (rsp_ch.ok),
   .rsp_slot_index   (rsp_ch.slot_index),
   .rsp_label_out    (rsp_ch.label_out),
   .rsp_active_count (rsp_ch.active_count),
   .rsp_free_count   (rsp_ch.free_count)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the recency slot allocator core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS           = 63;
   localparam int ITEMS_PER_PHASE = 175;   // four idling phases, ~700 random transfers
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES    = 250;   // length of the quiet tail at the end of the run
   localparam int CYCLE_LIMIT     = 1_000_000;

   // Function codes the block does not define; they must change nothing.
   localparam logic [rsa_pkg::FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
   localparam logic [rsa_pkg::FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
   localparam logic [rsa_pkg::FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

   // Label carried by each slot. Every label 1..63 appears exactly once.
   localparam logic [5:0] SLOT_TAG [SLOTS] = '{
      6'd58, 6'd10, 6'd15, 6'd1,  6'd27, 6'd52, 6'd14, 6'd3,
      6'd61, 6'd13, 6'd31, 6'd30, 6'd45, 6'd28, 6'd41, 6'd55,
      6'd33, 6'd20, 6'd62, 6'd34, 6'd42, 6'd18, 6'd57, 6'd47,
      6'd24, 6'd49, 6'd19, 6'd50, 6'd25, 6'd38, 6'd40, 6'd2,
      6'd21, 6'd39, 6'd59, 6'd22, 6'd60, 6'd4,  6'd6,  6'd16,
      6'd29, 6'd37, 6'd48, 6'd46, 6'd54, 6'd43, 6'd32, 6'd56,
      6'd51, 6'd7,  6'd9,  6'd63, 6'd5,  6'd8,  6'd36, 6'd44,
      6'd26, 6'd11, 6'd23, 6'd17, 6'd53, 6'd35, 6'd12
   };

   typedef struct packed {
      logic                        ok;
      logic [rsa_pkg::SLOT_W-1:0]  slot_index;
      logic [rsa_pkg::LBOUT_W-1:0] label_out;
      logic [rsa_pkg::COUNT_W-1:0] active_count;
      logic [rsa_pkg::COUNT_W-1:0] free_count;
   } pool_result_type;

   typedef struct packed {
      logic [rsa_pkg::FUNC_W-1:0]  func;
      logic [rsa_pkg::LABEL_W-1:0] label;
      logic [rsa_pkg::RANK_W-1:0]  rank;
      logic                        typed;   // 1: use the typed-in result, else the predictor
      pool_result_type             want;
   } stim_row_type;

   // Opening sequence. Typed results are the obvious ones: empty pool, bad labels,
   // first creates, out-of-range ranks, undefined codes.
   localparam stim_row_type OPENING [25] = '{
      '{rsa_pkg::FUNC_READ_RANK, 8'd0,   6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_READ_RANK, 8'd255, 6'd62, 1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd58,  6'd0,  1'b1, '{1'b1, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd12,  6'd63, 1'b1, '{1'b1, 6'd62, 6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd0,   6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd255, 6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd64,  6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CHECK,     8'd128, 6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_FETCH,     8'd58,  6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_FORGET,    8'd58,  6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd0, 6'd63}},
      '{rsa_pkg::FUNC_CREATE,    8'd0,   6'd0,  1'b1, '{1'b1, 6'd0,  6'd58, 6'd1, 6'd62}},
      '{rsa_pkg::FUNC_CREATE,    8'd255, 6'd62, 1'b1, '{1'b1, 6'd1,  6'd10, 6'd2, 6'd61}},
      '{rsa_pkg::FUNC_CREATE,    8'd0,   6'd0,  1'b1, '{1'b1, 6'd2,  6'd15, 6'd3, 6'd60}},
      '{rsa_pkg::FUNC_READ_RANK, 8'd0,   6'd0,  1'b0, '0},
      '{rsa_pkg::FUNC_READ_RANK, 8'd0,   6'd2,  1'b0, '0},
      '{rsa_pkg::FUNC_READ_RANK, 8'd0,   6'd3,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}},
      '{rsa_pkg::FUNC_FETCH,     8'd10,  6'd0,  1'b0, '0},
      '{rsa_pkg::FUNC_FETCH,     8'd0,   6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}},
      '{rsa_pkg::FUNC_FORGET,    8'd10,  6'd0,  1'b0, '0},
      '{rsa_pkg::FUNC_FORGET,    8'd10,  6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd2, 6'd61}},
      '{rsa_pkg::FUNC_CREATE,    8'd0,   6'd0,  1'b0, '0},
      '{rsa_pkg::FUNC_FORGET,    8'd0,   6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}},
      '{FUNC_RSVD_5,             8'd58,  6'd0,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}},
      '{FUNC_RSVD_6,             8'd15,  6'd1,  1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}},
      '{FUNC_RSVD_7,             8'd255, 6'd62, 1'b1, '{1'b0, 6'd0,  6'd0,  6'd3, 6'd60}}
   };

   logic clock;
   logic reset;

   rsa_req_if req_ch ();
   rsa_rsp_if rsp_ch ();

   recency_slot_allocator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted pool state: recency list, its inverse, in-use flags, count.
   logic [5:0] rank_slot [64];
   logic [5:0] slot_rank [64];
   bit         slot_live [64];
   int         live_total;

   pool_result_type awaited [$];   // results still owed by the block, oldest first

   int fault_count;
   int sender_gap_pct;
   int rsp_stall_pct;
   bit hold_ask;    // raised by the sender side, served by the receiver process
   bit draining;    // random mix leans to forget instead of create
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Slot of a label, or -1. Label zero and anything above 63 match nothing.
   function automatic int label_slot(logic [rsa_pkg::LABEL_W-1:0] lbl);
      int i;
      if (lbl == '0 || lbl > rsa_pkg::LABEL_W'(63)) return -1;
      for (i = 0; i < SLOTS; i++) begin
         if (SLOT_TAG[i] == lbl[5:0]) return i;
      end
      return -1;
   endfunction

   function automatic void pool_clear();
      int i;
      for (i = 0; i < 64; i++) begin
         rank_slot[i] = 6'(i);
         slot_rank[i] = 6'(i);
         slot_live[i] = 1'b0;
      end
      live_total = 0;
   endfunction

   // Applies one operation to the predicted pool and returns the result it gives.
   function automatic pool_result_type pool_apply(logic [rsa_pkg::FUNC_W-1:0] f,
                                                  logic [rsa_pkg::LABEL_W-1:0] lbl,
                                                  logic [rsa_pkg::RANK_W-1:0] rk);
      pool_result_type r;
      int s;
      int d;
      int n;
      int i;
      int j;
      r = '0;
      s = label_slot(lbl);
      case (f)
         rsa_pkg::FUNC_CREATE: begin
            for (i = 0; i < SLOTS; i++) begin
               if (!r.ok && !slot_live[i]) begin
                  // lowest free slot jumps to rank 0, ranks ahead of it slide back
                  d = int'(slot_rank[i]);
                  for (j = d; j > 0; j--) begin
                     rank_slot[j] = rank_slot[j-1];
                     slot_rank[rank_slot[j]] = 6'(j);
                  end
                  rank_slot[0] = 6'(i);
                  slot_rank[i] = '0;
                  slot_live[i] = 1'b1;
                  live_total++;
                  r.ok         = 1'b1;
                  r.slot_index = 6'(i);
                  r.label_out  = SLOT_TAG[i];
               end
            end
         end
         rsa_pkg::FUNC_FORGET: begin
            if (s >= 0 && slot_live[s]) begin
               // slot goes to the last active rank, ranks behind it close up
               d = int'(slot_rank[s]);
               n = live_total - 1;
               for (j = d; j < n; j++) begin
                  rank_slot[j] = rank_slot[j+1];
                  slot_rank[rank_slot[j]] = 6'(j);
               end
               rank_slot[n] = 6'(s);
               slot_rank[s] = 6'(n);
               slot_live[s] = 1'b0;
               live_total--;
               r.ok         = 1'b1;
               r.slot_index = 6'(s);
            end
         end
         rsa_pkg::FUNC_FETCH: begin
            if (s >= 0 && slot_live[s]) begin
               r.ok         = 1'b1;
               r.slot_index = 6'(s);
            end
         end
         rsa_pkg::FUNC_READ_RANK: begin
            if (int'(rk) < live_total) begin
               r.ok         = 1'b1;
               r.slot_index = rank_slot[rk];
               r.label_out  = SLOT_TAG[rank_slot[rk]];
            end
         end
         rsa_pkg::FUNC_CHECK: begin
            // valid label reports its slot whether active or not
            if (s >= 0) begin
               r.ok         = 1'b1;
               r.slot_index = 6'(s);
            end
         end
         default: ;
      endcase
      r.active_count = rsa_pkg::COUNT_W'(live_total);
      r.free_count   = rsa_pkg::COUNT_W'(SLOTS - live_total);
      return r;
   endfunction

   // Offers one request, with random idle cycles ahead of it, and waits for the
   // transfer. valid stays high into the next call unless that call idles first.
   task automatic offer(input logic [rsa_pkg::FUNC_W-1:0] f,
                        input logic [rsa_pkg::LABEL_W-1:0] lbl,
                        input logic [rsa_pkg::RANK_W-1:0] rk, input bit typed,
                        input pool_result_type want);
      pool_result_type predicted;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= f;
      req_ch.label <= lbl;
      req_ch.rank  <= rk;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // transfer taken at this edge: advance the predicted pool
      predicted = pool_apply(f, lbl, rk);
      awaited   = {awaited, (typed ? want : predicted)};
   endtask

   // Mostly any 1..63, sometimes the full byte so the upper bits toggle.
   function automatic logic [rsa_pkg::LABEL_W-1:0] rand_label();
      if ($urandom_range(9) < 7) return rsa_pkg::LABEL_W'($urandom_range(63, 1));
      return rsa_pkg::LABEL_W'($urandom_range(255));
   endfunction

   // Random request shaped by the pool: mostly creates until full, then mostly forgets until
   // empty, so rank shuffles of every length and pool-full creates occur.
   task automatic random_item();
      logic [rsa_pkg::FUNC_W-1:0]  f;
      logic [rsa_pkg::LABEL_W-1:0] lbl;
      logic [rsa_pkg::RANK_W-1:0]  rk;
      int roll;
      int create_pct;
      int forget_pct;
      if (!draining && live_total == SLOTS && $urandom_range(7) == 0) draining = 1'b1;
      else if (draining && live_total == 0 && $urandom_range(7) == 0) draining = 1'b0;
      create_pct = draining ? 10 : 50;
      forget_pct = draining ? 45 : 12;
      lbl  = rand_label();
      rk   = rsa_pkg::RANK_W'($urandom_range(SLOTS - 1));
      roll = $urandom_range(99);
      if (roll < create_pct) begin
         f = rsa_pkg::FUNC_CREATE;
      end else if (roll < create_pct + forget_pct) begin
         f = rsa_pkg::FUNC_FORGET;
         if (live_total > 0)
            lbl = rsa_pkg::LABEL_W'(SLOT_TAG[rank_slot[$urandom_range(live_total - 1)]]);
      end else begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            f = rsa_pkg::FUNC_FORGET;
         end else if (roll < 35) begin
            f = rsa_pkg::FUNC_FETCH;
            if (live_total > 0)
               lbl = rsa_pkg::LABEL_W'(SLOT_TAG[rank_slot[$urandom_range(live_total - 1)]]);
         end else if (roll < 45) begin
            f = rsa_pkg::FUNC_FETCH;
         end else if (roll < 70) begin
            f = rsa_pkg::FUNC_READ_RANK;
            if (live_total > 0 && $urandom_range(3) != 0)
               rk = rsa_pkg::RANK_W'($urandom_range(live_total - 1));
         end else if (roll < 93) begin
            f = rsa_pkg::FUNC_CHECK;
         end else begin
            f = rsa_pkg::FUNC_W'($urandom_range(FUNC_RSVD_7, FUNC_RSVD_5));
         end
      end
      offer(f, lbl, rk, 1'b0, '0);
   endtask

   task automatic field_check(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      pool_result_type want;
      if (awaited.size() == 0) begin
         fault_count++;
         $display("%0t: unexpected result transfer, expected none, actual ok=%0d slot=%0d",
                  $time, rsp_ch.ok, rsp_ch.slot_index);
      end else begin
         want = awaited.pop_front();
         field_check("ok",           8'(want.ok),           8'(rsp_ch.ok));
         field_check("slot_index",   8'(want.slot_index),   8'(rsp_ch.slot_index));
         field_check("label_out",    8'(want.label_out),    8'(rsp_ch.label_out));
         field_check("active_count", 8'(want.active_count), 8'(rsp_ch.active_count));
         field_check("free_count",   8'(want.free_count),   8'(rsp_ch.free_count));
      end
   endtask

   // Receiver: checks each result transfer at the edge it happens, then picks
   // ready for the next cycle. The long hold-off is counted here.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog on total run length.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Sender and run control.
   initial begin
      int phase;
      int k;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.func    = rsa_pkg::FUNC_CREATE;
      req_ch.label   = '0;
      req_ch.rank    = '0;
      fault_count    = 0;
      sender_gap_pct = 0;
      rsp_stall_pct  = 0;
      hold_ask       = 1'b0;
      draining       = 1'b0;
      pool_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(OPENING); k++) begin
         offer(OPENING[k].func, OPENING[k].label, OPENING[k].rank,
               OPENING[k].typed, OPENING[k].want);
      end

      // Idling phases: none, sender idle, receiver stalling, both lightly.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_gap_pct = 59; rsp_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  rsp_stall_pct = 59; end
            default: begin sender_gap_pct = 13; rsp_stall_pct = 13; end
         endcase
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // receiver goes quiet while requests keep coming: output register
            // and sequencer fill, then request ready drops
            if (phase == 0 && k == 60) hold_ask = 1'b1;
            random_item();
         end
         // pause the sender until every owed result has come back
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (awaited.size() != 0) @(posedge clock);
      end

      // quiet tail: anything arriving now is a spurious transfer
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> recency_slot_allocator_core.f
rtl/core/rsa_pkg.sv
rtl/core/rsa_req_if.sv
rtl/core/rsa_rsp_if.sv
rtl/core/rsa_ctrl.sv
rtl/core/rsa_datapath.sv
rtl/core/recency_slot_allocator_core.sv
rtl/core/rsa_checker.sv
tb/sv/testbench.sv
